// File: rtl/slbo_pkg.sv
// Package for the slot list with box overlap query unit.
// Holds the box type, cell control types, state and command codes.
// No dependencies.
`timescale 1ns / 1ps
package slbo_pkg;

    localparam int SLOTS_DEF = 64;

    localparam logic [2:0] CMD_INSERT = 3'd0;
    localparam logic [2:0] CMD_REMOVE = 3'd1;
    localparam logic [2:0] CMD_MOVE   = 3'd2;
    localparam logic [2:0] CMD_QUERY  = 3'd3;
    localparam logic [2:0] CMD_CRESET = 3'd4;
    localparam logic [2:0] CMD_CNEXT  = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOT_LIVE = 2'd2;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [11:0]        hw;
        logic [11:0]        hh;
    } t_box;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_ROTATE,
        CELL_COMPACT,
        CELL_WRITE,
        CELL_MOVE
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        logic     phase;
    } t_cell_ctl;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INS_SCAN,
        S_REM_PASS,
        S_COMPACT,
        S_MOVE_WR,
        S_QRY_FIND,
        S_QRY_WALK,
        S_CNEXT_PASS,
        S_DONE
    } t_state;

endpackage

// File: rtl/slbo_cell.sv
// One list position of the slot list: valid flag, slot number and box.
// Rotates, compacts, loads and moves under control from the top level.
// Depends on slbo_pkg.
`timescale 1ns / 1ps
module slbo_cell #(
    parameter int PW    = 6,
    parameter int INDEX = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  slbo_pkg::t_cell_ctl  i_ctl,
    input  logic [PW-1:0]        i_key,
    input  logic [PW-1:0]        i_wr_pos,
    input  slbo_pkg::t_box       i_wr_box,
    input  logic                 i_r_valid,
    input  logic [PW-1:0]        i_r_id,
    input  slbo_pkg::t_box       i_r_box,
    input  logic                 i_l_valid,
    output logic                 o_valid,
    output logic [PW-1:0]        o_id,
    output slbo_pkg::t_box       o_box
);
    import slbo_pkg::*;

    localparam logic ODD = 1'(INDEX % 2);

    logic          r_valid;
    logic [PW-1:0] r_id;
    t_box          r_box;
    logic          n_valid;
    logic [PW-1:0] n_id;
    t_box          n_box;

    always_comb begin
        n_valid = r_valid;
        n_id    = r_id;
        n_box   = r_box;
        unique case (i_ctl.op)
            CELL_ROTATE: begin
                n_valid = i_r_valid;
                n_id    = i_r_id;
                n_box   = i_r_box;
            end
            CELL_COMPACT: begin
                if (i_ctl.phase == ODD) begin
                    if (!r_valid && i_r_valid) begin
                        n_valid = 1'b1;
                        n_id    = i_r_id;
                        n_box   = i_r_box;
                    end
                end else if (!i_l_valid && r_valid) begin
                    n_valid = 1'b0;
                end
            end
            CELL_WRITE: begin
                if (i_wr_pos == PW'(INDEX)) begin
                    n_valid = 1'b1;
                    n_id    = i_key;
                    n_box   = i_wr_box;
                end
            end
            CELL_MOVE: begin
                if (r_valid && r_id == i_key) begin
                    n_box.x = i_wr_box.x;
                    n_box.y = i_wr_box.y;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id  <= n_id;
        r_box <= n_box;
    end

    assign o_valid = r_valid;
    assign o_id    = r_id;
    assign o_box   = r_box;

endmodule

// File: rtl/slot_list_with_box_overlap_query_unit.sv
// Top level of the slot list with box overlap query unit.
// Sequencer and a ring of slbo_cell list positions; depends on slbo_pkg and slbo_cell.
// The list is kept in cell order, head in cell 0, and is read by rotating the ring.
`timescale 1ns / 1ps
// One transaction is taken at a time. Insert scans the slot numbers up to the lowest free one,
// remove makes a full rotation of the ring of SLOTS cells through cell 0 and then the odd-even
// compaction, an overlap query makes two full rotations, cursor next one, and move writes in
// place. The other commands, a rejected command and cursor next with no successor go straight
// to the result. A result waits in an output register, and the next transaction is taken
// meanwhile.
module slot_list_with_box_overlap_query_unit #(
    parameter int SLOTS = slbo_pkg::SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // slot[5:0], pos_x[21:6], pos_y[37:22], half_w[49:38], half_h[61:50], zeros above.
    input  logic [63:0] s_axis_tdata,
    // cmd[2:0].
    input  logic [2:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // result_slot[5:0], result_valid[6], status[8:7], live_count[15:9].
    output logic [15:0] m_axis_tdata
);
    import slbo_pkg::*;

    localparam int PW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);
    localparam int IW = (PW > 6) ? PW : 6;
    localparam logic [PW-1:0] LAST = PW'(SLOTS - 1);

    t_state        r_state;
    t_state        n_state;
    logic [PW-1:0] r_step;
    logic [PW-1:0] r_key;
    t_box          r_box;
    t_box          r_qbox;
    logic [CW-1:0] r_cnt;
    logic [PW-1:0] r_cur;
    logic          r_cur_ok;
    logic [SLOTS-1:0] r_in_use;
    logic [PW-1:0] r_rpos;
    logic          r_found;
    logic [PW-1:0] r_res_slot;
    logic          r_res_valid;
    logic [1:0]    r_status;
    logic          r_m_valid;
    logic [15:0]   r_m_data;

    logic          c_valid [SLOTS];
    logic [PW-1:0] c_id [SLOTS];
    t_box          c_box [SLOTS];

    t_cell_ctl     ctl;
    logic [PW-1:0] ctl_key;
    logic          feed_valid;

    logic          accept;
    logic [2:0]    in_cmd;
    logic [IW-1:0] s_ext;
    logic          s_live;
    logic          full;
    logic [1:0]    acc_status;
    logic          last_step;
    logic          head_hit;
    logic          scan_free;
    logic          out_free;
    logic          next_ok;
    logic signed [16:0] dx;
    logic signed [16:0] dy;
    logic [16:0]   adx;
    logic [16:0]   ady;
    logic [12:0]   sum_w;
    logic [12:0]   sum_h;
    logic          overlap;
    logic          cand;

    assign in_cmd    = s_axis_tuser;
    assign s_ext     = IW'(s_axis_tdata[5:0]);
    assign s_live    = ((IW + 1)'({1'b0, s_ext}) < (IW + 1)'(SLOTS))
                       && r_in_use[s_ext[PW-1:0]];
    assign full      = (r_cnt == CW'(SLOTS));
    assign accept    = s_axis_tvalid && s_axis_tready;
    assign last_step = (r_step == LAST);
    assign head_hit  = c_valid[0] && (c_id[0] == r_key);
    assign scan_free = !r_in_use[r_step];
    assign out_free  = !r_m_valid || m_axis_tready;
    assign next_ok   = r_cur_ok && ((CW'(r_cur) + CW'(1)) < r_cnt);

    assign dx    = 17'(c_box[0].x) - 17'(r_qbox.x);
    assign dy    = 17'(c_box[0].y) - 17'(r_qbox.y);
    assign adx   = (dx < 0) ? 17'(-dx) : 17'(dx);
    assign ady   = (dy < 0) ? 17'(-dy) : 17'(dy);
    assign sum_w = 13'(c_box[0].hw) + 13'(r_qbox.hw);
    assign sum_h = 13'(c_box[0].hh) + 13'(r_qbox.hh);
    assign overlap = (adx < 17'(sum_w)) && (ady < 17'(sum_h));
    assign cand    = c_valid[0] && (c_id[0] != r_key) && overlap;

    assign s_axis_tready = (r_state == S_IDLE) && i_rst_n;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

    genvar k;
    generate
        for (k = 0; k < SLOTS; k++) begin : g_cell
            logic          rv;
            logic [PW-1:0] rid;
            t_box          rbox;
            logic          lv;
            if (k == SLOTS - 1) begin : g_tail
                assign rv   = feed_valid;
                assign rid  = c_id[0];
                assign rbox = c_box[0];
            end else begin : g_mid
                assign rv   = c_valid[k+1];
                assign rid  = c_id[k+1];
                assign rbox = c_box[k+1];
            end
            if (k == 0) begin : g_head
                assign lv = 1'b1;
            end else begin : g_left
                assign lv = c_valid[k-1];
            end
            slbo_cell #(
                .PW    (PW),
                .INDEX (k)
            ) u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_ctl     (ctl),
                .i_key     (ctl_key),
                .i_wr_pos  (r_cnt[PW-1:0]),
                .i_wr_box  (r_box),
                .i_r_valid (rv),
                .i_r_id    (rid),
                .i_r_box   (rbox),
                .i_l_valid (lv),
                .o_valid   (c_valid[k]),
                .o_id      (c_id[k]),
                .o_box     (c_box[k])
            );
        end
    endgenerate

    always_comb begin
        acc_status = ST_OK;
        unique case (in_cmd)
            CMD_INSERT: begin
                if (full) begin
                    acc_status = ST_FULL;
                end
            end
            CMD_REMOVE,
            CMD_MOVE,
            CMD_QUERY: begin
                if (!s_live) begin
                    acc_status = ST_NOT_LIVE;
                end
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    priority case (in_cmd)
                        CMD_INSERT: n_state = full ? S_DONE : S_INS_SCAN;
                        CMD_REMOVE: n_state = s_live ? S_REM_PASS : S_DONE;
                        CMD_MOVE:   n_state = s_live ? S_MOVE_WR : S_DONE;
                        CMD_QUERY:  n_state = s_live ? S_QRY_FIND : S_DONE;
                        CMD_CNEXT:  n_state = next_ok ? S_CNEXT_PASS : S_DONE;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_INS_SCAN:   n_state = scan_free ? S_DONE : S_INS_SCAN;
            S_REM_PASS:   n_state = last_step ? S_COMPACT : S_REM_PASS;
            S_COMPACT:    n_state = last_step ? S_DONE : S_COMPACT;
            S_MOVE_WR:    n_state = S_DONE;
            S_QRY_FIND:   n_state = last_step ? S_QRY_WALK : S_QRY_FIND;
            S_QRY_WALK:   n_state = last_step ? S_DONE : S_QRY_WALK;
            S_CNEXT_PASS: n_state = last_step ? S_DONE : S_CNEXT_PASS;
            S_DONE:       n_state = out_free ? S_IDLE : S_DONE;
            default:      n_state = S_IDLE;
        endcase
    end

    always_comb begin
        ctl.op     = CELL_HOLD;
        ctl.phase  = r_step[0];
        ctl_key    = r_key;
        feed_valid = c_valid[0];
        unique case (r_state)
            S_INS_SCAN: begin
                ctl_key = r_step;
                if (scan_free) begin
                    ctl.op = CELL_WRITE;
                end
            end
            S_REM_PASS: begin
                ctl.op     = CELL_ROTATE;
                feed_valid = c_valid[0] && !head_hit;
            end
            S_COMPACT: begin
                ctl.op     = CELL_COMPACT;
                feed_valid = 1'b0;
            end
            S_MOVE_WR:    ctl.op = CELL_MOVE;
            S_QRY_FIND,
            S_QRY_WALK,
            S_CNEXT_PASS: ctl.op = CELL_ROTATE;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_cnt       <= '0;
            r_cur       <= '0;
            r_cur_ok    <= 1'b0;
            r_in_use    <= '0;
            r_found     <= 1'b0;
            r_res_valid <= 1'b0;
            r_status    <= ST_OK;
            r_m_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= (n_state != r_state) ? '0 : r_step + PW'(1);
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_res_valid <= (in_cmd == CMD_CRESET) && (r_cnt != '0);
                        r_status    <= acc_status;
                        r_found     <= 1'b0;
                        if (in_cmd == CMD_CRESET) begin
                            r_cur    <= '0;
                            r_cur_ok <= (r_cnt != '0);
                        end else if (in_cmd == CMD_CNEXT && !next_ok) begin
                            r_cur_ok <= 1'b0;
                        end
                    end
                end
                S_INS_SCAN: begin
                    if (scan_free) begin
                        r_in_use[r_step] <= 1'b1;
                        r_cnt            <= r_cnt + CW'(1);
                        r_res_valid      <= 1'b1;
                    end
                end
                S_COMPACT: begin
                    if (last_step) begin
                        r_in_use[r_key] <= 1'b0;
                        r_cnt           <= r_cnt - CW'(1);
                        if (r_cur_ok) begin
                            if (r_rpos == r_cur) begin
                                if (!((CW'(r_rpos) + CW'(1)) < r_cnt)) begin
                                    if (r_rpos == '0) begin
                                        r_cur_ok <= 1'b0;
                                    end else begin
                                        r_cur <= r_rpos - PW'(1);
                                    end
                                end
                            end else if (r_rpos < r_cur) begin
                                r_cur <= r_cur - PW'(1);
                            end
                        end
                    end
                end
                S_QRY_WALK: begin
                    if (!r_found && cand) begin
                        r_found     <= 1'b1;
                        r_res_valid <= 1'b1;
                    end
                end
                S_CNEXT_PASS: begin
                    if (last_step) begin
                        r_cur       <= r_cur + PW'(1);
                        r_res_valid <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
            if (r_state == S_DONE && out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key      <= s_ext[PW-1:0];
            r_box.x    <= s_axis_tdata[21:6];
            r_box.y    <= s_axis_tdata[37:22];
            r_box.hw   <= s_axis_tdata[49:38];
            r_box.hh   <= s_axis_tdata[61:50];
            r_res_slot <= (in_cmd == CMD_CRESET && r_cnt != '0) ? c_id[0] : '0;
        end
        if (r_state == S_INS_SCAN && scan_free) begin
            r_res_slot <= r_step;
        end
        if (r_state == S_REM_PASS && head_hit) begin
            r_rpos <= r_step;
        end
        if (r_state == S_QRY_FIND && head_hit) begin
            r_qbox <= c_box[0];
        end
        if (r_state == S_QRY_WALK && !r_found && cand) begin
            r_res_slot <= c_id[0];
        end
        if (r_state == S_CNEXT_PASS && r_step == PW'(r_cur + PW'(1))) begin
            r_res_slot <= c_id[0];
        end
        if (r_state == S_DONE && out_free) begin
            r_m_data <= {7'(r_cnt), r_status, r_res_valid, 6'(r_res_slot)};
        end
    end

endmodule

// File: test/tb_slot_list_with_box_overlap_query_unit.sv
// Testbench for the slot list with box overlap query unit.
// Drives command transactions, predicts each result with an internal model and checks it.
// Depends on slbo_pkg and the top level slot_list_with_box_overlap_query_unit.
`timescale 1ns / 1ps
module tb_slot_list_with_box_overlap_query_unit;
    import slbo_pkg::*;

    localparam int NSLOT = 64;
    localparam int NIL = NSLOT;
    localparam int WATCH_LIMIT = 20000;

    typedef struct packed {
        logic [6:0] live;
        logic [1:0] status;
        logic       valid;
        logic [5:0] slot;
    } t_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;

    // Mirror of the slot table.
    bit          live_q [NSLOT];
    int          prv [NSLOT];
    int          nxt [NSLOT];
    int          bx [NSLOT];
    int          by [NSLOT];
    int          bw [NSLOT];
    int          bh [NSLOT];
    int          head_q, tail_q, cur_q, used_q;

    t_res        pending_q[$];
    int          errors;
    int          n_sent, n_got, n_hits, n_full;
    int          send_idle, recv_stall;
    bit          hold_recv;
    int          quiet;

    slot_list_with_box_overlap_query_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic bit boxes_touch(int a, int b);
        int dx, dy;
        dx = bx[a] - bx[b];
        dy = by[a] - by[b];
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        return (dx < bw[a] + bw[b]) && (dy < bh[a] + bh[b]);
    endfunction

    function automatic t_res apply_command(logic [2:0] cmd, int s, int px, int py,
                                           int hw, int hh);
        t_res r;
        int   i, n, p, q;
        r = '0;
        r.status = ST_OK;
        case (cmd)
            CMD_INSERT: begin
                i = 0;
                while (i < NSLOT && live_q[i]) i++;
                if (i >= NSLOT) begin
                    r.status = ST_FULL;
                end else begin
                    live_q[i] = 1'b1;
                    bx[i] = px; by[i] = py; bw[i] = hw; bh[i] = hh;
                    prv[i] = tail_q;
                    nxt[i] = NIL;
                    if (tail_q < NSLOT) nxt[tail_q] = i;
                    else head_q = i;
                    tail_q = i;
                    used_q++;
                    r.slot = 6'(i);
                    r.valid = 1'b1;
                end
            end
            CMD_REMOVE: begin
                if (!live_q[s]) begin
                    r.status = ST_NOT_LIVE;
                end else begin
                    p = prv[s];
                    q = nxt[s];
                    if (p < NSLOT) nxt[p] = q;
                    if (q < NSLOT) prv[q] = p;
                    if (head_q == s) head_q = q;
                    if (tail_q == s) tail_q = p;
                    if (cur_q == s) cur_q = (q < NSLOT) ? q : p;
                    live_q[s] = 1'b0;
                    used_q--;
                end
            end
            CMD_MOVE: begin
                if (!live_q[s]) r.status = ST_NOT_LIVE;
                else begin
                    bx[s] = px; by[s] = py;
                end
            end
            CMD_QUERY: begin
                if (!live_q[s]) begin
                    r.status = ST_NOT_LIVE;
                end else begin
                    i = head_q;
                    for (n = 0; n < NSLOT && i < NSLOT; n++) begin
                        if (i != s && boxes_touch(s, i)) begin
                            r.slot = 6'(i);
                            r.valid = 1'b1;
                            break;
                        end
                        i = nxt[i];
                    end
                end
            end
            CMD_CRESET: begin
                cur_q = head_q;
                if (cur_q < NSLOT) begin
                    r.slot = 6'(cur_q);
                    r.valid = 1'b1;
                end
            end
            CMD_CNEXT: begin
                if (cur_q < NSLOT) begin
                    cur_q = nxt[cur_q];
                    if (cur_q < NSLOT) begin
                        r.slot = 6'(cur_q);
                        r.valid = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        r.live = 7'(used_q);
        return r;
    endfunction

    task automatic send_item(logic [2:0] cmd, logic [5:0] s, logic [15:0] px,
                             logic [15:0] py, logic [11:0] hw, logic [11:0] hh);
        t_res r;
        @(posedge i_clk);
        while (send_idle > 0 && $urandom_range(99) < send_idle) @(posedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {2'b00, hh, hw, py, px, s};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        r = apply_command(cmd, int'(s), int'($signed(px)), int'($signed(py)),
                          int'(hw), int'(hh));
        pending_q.push_back(r);
        if (r.valid && cmd == CMD_QUERY) n_hits++;
        if (r.status == ST_FULL) n_full++;
        n_sent++;
        s_axis_tvalid <= 1'b0;
    endtask

    task automatic drain;
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (4 * NSLOT) @(posedge i_clk);
    endtask

    function automatic int live_pick();
        int k;
        k = $urandom_range(NSLOT - 1);
        if (used_q != 0) while (!live_q[k]) k = (k + 1) % NSLOT;
        return k;
    endfunction

    // Result checking.
    always @(posedge i_clk) begin
        t_res want, got;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= hold_recv ? 1'b0 :
                             (recv_stall == 0) ? 1'b1 : ($urandom_range(99) >= recv_stall);
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                n_got++;
                if (pending_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result %h", $time, got);
                end else begin
                    want = pending_q.pop_front();
                    if (got.slot !== want.slot || got.valid !== want.valid ||
                        got.status !== want.status || got.live !== want.live) begin
                        errors++;
                        $display("%0t: mismatch, expected slot %0d valid %0d status %0d live %0d",
                                 $time, want.slot, want.valid, want.status, want.live);
                        $display("%0t: mismatch, actual slot %0d valid %0d status %0d live %0d",
                                 $time, got.slot, got.valid, got.status, got.live);
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any accepted transaction, outside a hold of the receiver.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            hold_recv)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet > WATCH_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic test_directed;
        send_item(CMD_CRESET, 0, 0, 0, 0, 0);
        send_item(CMD_CNEXT, 0, 0, 0, 0, 0);
        send_item(CMD_REMOVE, 6'd63, 0, 0, 0, 0);
        send_item(CMD_MOVE, 6'd0, 16'h7fff, 16'h8000, 0, 0);
        send_item(CMD_QUERY, 6'd5, 0, 0, 0, 0);
        send_item(CMD_INSERT, 0, 16'h8000, 16'h8000, 12'hfff, 12'hfff);
        send_item(CMD_INSERT, 0, 16'h7fff, 16'h7fff, 12'hfff, 12'hfff);
        send_item(CMD_INSERT, 0, 16'd10, 16'd10, 12'd0, 12'd0);
        send_item(CMD_INSERT, 0, 16'd12, 16'd10, 12'd2, 12'd1);
        send_item(CMD_QUERY, 6'd2, 0, 0, 0, 0);
        send_item(CMD_QUERY, 6'd3, 0, 0, 0, 0);
        send_item(CMD_QUERY, 6'd0, 0, 0, 0, 0);
        send_item(CMD_CRESET, 0, 0, 0, 0, 0);
        send_item(CMD_CNEXT, 0, 0, 0, 0, 0);
        send_item(CMD_REMOVE, 6'd1, 0, 0, 0, 0);
        send_item(CMD_CNEXT, 0, 0, 0, 0, 0);
        send_item(CMD_REMOVE, 6'd3, 0, 0, 0, 0);
        send_item(CMD_MOVE, 6'd2, 16'd11, 16'd10, 0, 0);
        send_item(3'd6, 6'h2a, 16'h5555, 16'haaaa, 12'h555, 12'haaa);
        send_item(3'd7, 6'h15, 16'haaaa, 16'h5555, 12'haaa, 12'h555);
        send_item(CMD_REMOVE, 6'd0, 0, 0, 0, 0);
        send_item(CMD_REMOVE, 6'd2, 0, 0, 0, 0);
        send_item(CMD_CNEXT, 0, 0, 0, 0, 0);
        drain();
    endtask

    task automatic test_fill_table;
        for (int k = 0; k < NSLOT + 2; k++)
            send_item(CMD_INSERT, 6'($urandom), 16'($urandom), 16'($urandom),
                      12'($urandom), 12'($urandom));
        send_item(CMD_QUERY, 6'd63, 0, 0, 0, 0);
        for (int k = 0; k < 20; k++)
            send_item(CMD_REMOVE, 6'($urandom), 0, 0, 0, 0);
        drain();
    endtask

    task automatic random_phase(int count);
        int c, k;
        logic [2:0] cmd;
        for (int j = 0; j < count; j++) begin
            c = $urandom_range(99);
            if (c < 30 && used_q < NSLOT - 4 || used_q < 4)
                cmd = CMD_INSERT;
            else if (c < 45) cmd = CMD_REMOVE;
            else if (c < 60) cmd = CMD_MOVE;
            else if (c < 82) cmd = CMD_QUERY;
            else if (c < 88) cmd = CMD_CRESET;
            else if (c < 97) cmd = CMD_CNEXT;
            else cmd = 3'($urandom_range(7));
            k = ($urandom_range(9) == 0) ? $urandom_range(NSLOT - 1) : live_pick();
            send_item(cmd, 6'(k), 16'($urandom_range(600) - 300),
                      16'($urandom_range(600) - 300),
                      12'(($urandom_range(7) == 0) ? $urandom : $urandom_range(80)),
                      12'(($urandom_range(7) == 0) ? $urandom : $urandom_range(80)));
        end
        drain();
    endtask

    task automatic test_backpressure;
        fork
            begin
                hold_recv = 1'b1;
                repeat (600) @(posedge i_clk);
                hold_recv = 1'b0;
            end
            for (int k = 0; k < 12; k++) send_item(CMD_CRESET, 0, 0, 0, 0, 0);
        join
        drain();
    endtask

    initial begin
        errors = 0; n_sent = 0; n_got = 0; n_hits = 0; n_full = 0;
        send_idle = 0; recv_stall = 0; hold_recv = 1'b0;
        head_q = NIL; tail_q = NIL; cur_q = NIL; used_q = 0;
        for (int k = 0; k < NSLOT; k++) begin
            live_q[k] = 0; prv[k] = 0; nxt[k] = 0;
            bx[k] = 0; by[k] = 0; bw[k] = 0; bh[k] = 0;
        end
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_fill_table();
        random_phase(300);
        send_idle = 84;
        random_phase(250);
        send_idle = 0; recv_stall = 84;
        random_phase(250);
        send_idle = 10; recv_stall = 10;
        random_phase(300);
        send_idle = 0; recv_stall = 0;
        test_backpressure();
        random_phase(80);
        $display("Sent %0d transactions, checked %0d results, %0d query hits, %0d full inserts.",
                 n_sent, n_got, n_hits, n_full);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule

// File: filelist.f
rtl/slbo_pkg.sv
rtl/slbo_cell.sv
rtl/slot_list_with_box_overlap_query_unit.sv
test/tb_slot_list_with_box_overlap_query_unit.sv
